// File: rtl/arf_pkg.sv
// Package for the auto rate fallback controller.
// Holds command codes, register indexes, reset values and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arf_pkg;

  localparam int CMD_W     = 2;
  localparam int ATTEMPT_W = 8;
  localparam int SUCCESS_W = 12;
  localparam int RATE_W    = 4;
  localparam int TIMER_W   = 32;
  localparam int THR_W     = 12;
  localparam int CFG_THR_W = 10;
  localparam int NRATES_W  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TIMER_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_BACKOFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_THR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_RATES   = 3'd4;

  localparam logic [TIMER_W-1:0]   RST_TIMER_TICKS = 32'd1000;
  localparam logic [CFG_THR_W-1:0] RST_INIT_THR    = 10'd10;
  localparam logic [CFG_THR_W-1:0] RST_MAX_THR     = 10'd50;
  localparam logic [NRATES_W-1:0]  RST_NUM_RATES   = 5'd8;

  localparam logic [ATTEMPT_W-1:0] PROBE_FAIL_ATTEMPT = 8'd2;
  localparam logic [ATTEMPT_W-1:0] DOWN_ATTEMPT       = 8'd3;
  localparam logic [THR_W-1:0]     THR_SAT            = 12'hFFF;

  typedef struct packed {
    logic [TIMER_W-1:0]   timer_ticks;
    logic                 exp_backoff;
    logic [CFG_THR_W-1:0] init_thr;
    logic [CFG_THR_W-1:0] max_thr;
    logic [NRATES_W-1:0]  num_rates;
  } arf_cfg_t;

  typedef struct packed {
    logic [RATE_W-1:0] proposed_rate;
    logic              clear_success;
    logic              invalid_rate;
  } arf_result_t;

endpackage

`default_nettype wire

// File: rtl/auto_rate_fallback_controller.sv
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the single
// decision stage between the controller state and the result register sets that figure.
// A waiting result does not block the next request while the output is not stalled.
// Reset (rst, synchronous, active high) restores the register defaults,
// clears the rate, flags and timer, and loads the initial success threshold.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the auto rate fallback controller.
// Instantiates arf_cfg_regs and arf_core; uses arf_pkg.
module auto_rate_fallback_controller
  import arf_pkg::*;
#(
  parameter int MAX_RATES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Request channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic [ATTEMPT_W-1:0] attempt_count,
  input  wire logic [SUCCESS_W-1:0] success_count,
  input  wire logic [RATE_W-1:0]    rate_index,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [RATE_W-1:0]         proposed_rate,
  output logic                      clear_success,
  output logic                      invalid_rate,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  arf_cfg_t    cfg;
  arf_result_t result;
  logic        accept;

  // The result register can take a new request whenever it is empty or its
  // current content leaves in this same cycle.
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  // Registers are always writable; the host must only write while the block is idle.
  assign cfg_ready = 1'b1;

  arf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The core updates its state on the same edge that captures the result.
  arf_core #(
    .MAX_RATES (MAX_RATES)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cfg           (cfg),
    .command       (command),
    .attempt_count (attempt_count),
    .success_count (success_count),
    .rate_index    (rate_index),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      proposed_rate <= result.proposed_rate;
      clear_success <= result.clear_success;
      invalid_rate  <= result.invalid_rate;
    end
  end

endmodule

`default_nettype wire

// File: rtl/arf_cfg_regs.sv
// Configuration register file of the auto rate fallback controller.
// Depends on arf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arf_cfg_regs
  import arf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_DAT_W-1:0] wr_data,
  output arf_cfg_t                  cfg
);

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_ticks <= RST_TIMER_TICKS;
      cfg.exp_backoff <= 1'b0;
      cfg.init_thr    <= RST_INIT_THR;
      cfg.max_thr     <= RST_MAX_THR;
      cfg.num_rates   <= RST_NUM_RATES;
    end else if (wr_en) begin
      case (wr_index)
        REG_TIMER_TICKS: cfg.timer_ticks <= wr_data[TIMER_W-1:0];
        REG_EXP_BACKOFF: cfg.exp_backoff <= wr_data[0];
        REG_INIT_THR:    cfg.init_thr    <= wr_data[CFG_THR_W-1:0];
        REG_MAX_THR:     cfg.max_thr     <= wr_data[CFG_THR_W-1:0];
        REG_NUM_RATES:   cfg.num_rates   <= wr_data[NRATES_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/arf_core.sv
// Rate decision logic and controller state of the auto rate fallback block.
// Depends on arf_pkg; configuration comes from arf_cfg_regs.
`timescale 1ns / 1ps
`default_nettype none

module arf_core
  import arf_pkg::*;
#(
  parameter int MAX_RATES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire arf_cfg_t             cfg,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic [ATTEMPT_W-1:0] attempt_count,
  input  wire logic [SUCCESS_W-1:0] success_count,
  input  wire logic [RATE_W-1:0]    rate_index,
  output arf_result_t               result
);

  // Wide enough for the clamped rate count and for the 5-bit register value.
  localparam int CLOG_W = $clog2(MAX_RATES + 1);
  localparam int CNT_W  = (CLOG_W > NRATES_W) ? CLOG_W : NRATES_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RATES);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [RATE_W-1:0]  current_rate, current_rate_next;
  logic               probe_pending, probe_pending_next;
  logic               timeout_flag, timeout_flag_next;
  logic [THR_W-1:0]   success_threshold, success_threshold_next;
  logic               timer_armed, timer_armed_next;
  logic [TIMER_W-1:0] timer_remaining, timer_remaining_next;

  logic [CNT_W-1:0]  cnt_raw, rate_cnt, top, cur_ext, chosen_ext, up_ext;
  logic [RATE_W-1:0] up_rate, down_rate;
  logic [THR_W:0]    thr_dbl;
  logic [THR_W-1:0]  thr_half, init_ext;

  always_comb begin
    cnt_raw = CNT_W'(cfg.num_rates);
    if (cnt_raw == '0) begin
      rate_cnt = ONE_CNT;
    end else if (cnt_raw > MAX_CNT) begin
      rate_cnt = MAX_CNT;
    end else begin
      rate_cnt = cnt_raw;
    end
    top        = rate_cnt - ONE_CNT;
    cur_ext    = CNT_W'(current_rate);
    chosen_ext = CNT_W'(rate_index);
    up_ext     = (cur_ext < top) ? cur_ext + ONE_CNT : cur_ext;
    up_rate    = up_ext[RATE_W-1:0];
    down_rate  = (current_rate != '0) ? current_rate - RATE_W'(1) : current_rate;
    init_ext   = THR_W'(cfg.init_thr);
    thr_dbl    = {success_threshold, 1'b0};
    thr_half   = success_threshold >> 1;
  end

  always_comb begin
    current_rate_next      = current_rate;
    probe_pending_next     = probe_pending;
    timeout_flag_next      = timeout_flag;
    success_threshold_next = success_threshold;
    timer_armed_next       = timer_armed;
    timer_remaining_next   = timer_remaining;
    result.proposed_rate   = current_rate;
    result.clear_success   = 1'b0;
    result.invalid_rate    = 1'b0;

    case (command)
      CMD_QUERY: begin
        if (timeout_flag) begin
          result.proposed_rate = up_rate;
        end else if ((probe_pending && attempt_count == PROBE_FAIL_ATTEMPT) ||
                     attempt_count >= DOWN_ATTEMPT) begin
          result.proposed_rate = down_rate;
        end else if (success_count == success_threshold) begin
          result.proposed_rate = up_rate;
        end
      end
      CMD_COMMIT: begin
        if (chosen_ext > top) begin
          result.invalid_rate = 1'b1;
        end else begin
          timeout_flag_next = 1'b0;
          if (rate_index == current_rate) begin
            probe_pending_next = 1'b0;
          end else begin
            timer_armed_next     = 1'b0;
            timer_remaining_next = '0;
            if (rate_index < current_rate) begin
              timer_armed_next     = 1'b1;
              timer_remaining_next = cfg.timer_ticks;
              if (probe_pending) begin
                // Failed probe: with backoff on, back off by raising the threshold.
                probe_pending_next = 1'b0;
                if (cfg.exp_backoff &&
                    success_threshold < THR_W'(cfg.max_thr)) begin
                  success_threshold_next = thr_dbl[THR_W] ? THR_SAT
                                                          : thr_dbl[THR_W-1:0];
                end
              end else if (cfg.exp_backoff) begin
                success_threshold_next = (thr_half < init_ext) ? init_ext : thr_half;
              end
            end else begin
              probe_pending_next = 1'b1;
            end
            current_rate_next    = rate_index;
            result.clear_success = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (timer_armed) begin
          if (timer_remaining > TIMER_W'(1)) begin
            timer_remaining_next = timer_remaining - TIMER_W'(1);
          end else begin
            timer_armed_next     = 1'b0;
            timer_remaining_next = '0;
            if (cur_ext != top) begin
              timeout_flag_next = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_rate      <= '0;
      probe_pending     <= 1'b0;
      timeout_flag      <= 1'b0;
      success_threshold <= THR_W'(RST_INIT_THR);
      timer_armed       <= 1'b0;
      timer_remaining   <= '0;
    end else if (accept) begin
      current_rate      <= current_rate_next;
      probe_pending     <= probe_pending_next;
      timeout_flag      <= timeout_flag_next;
      success_threshold <= success_threshold_next;
      timer_armed       <= timer_armed_next;
      timer_remaining   <= timer_remaining_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/arf_checker.sv
// Port-level checker for the auto rate fallback controller, bound to the top.
// Depends on arf_pkg and on auto_rate_fallback_controller.
`timescale 1ns / 1ps
`default_nettype none

module arf_checker
  import arf_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [RATE_W-1:0] proposed_rate,
  input wire logic              clear_success,
  input wire logic              invalid_rate
);

  // A rejected commit never asks for the success counter to be cleared.
  a_invalid_no_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(invalid_rate && clear_success))
    else $error("invalid_rate and clear_success both set");

  // Every accepted request shows a result on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(proposed_rate) &&
                                  $stable(clear_success) && $stable(invalid_rate)))
    else $error("stalled result changed");

endmodule

bind auto_rate_fallback_controller arf_checker u_arf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .proposed_rate (proposed_rate),
  .clear_success (clear_success),
  .invalid_rate  (invalid_rate)
);

`default_nettype wire

// File: bench/auto_rate_fallback_controller_test.sv
// Self-checking testbench for the auto rate fallback controller.
// Drives queries, commits and timer ticks against an in-bench rate decision model.
// Depends on arf_pkg and auto_rate_fallback_controller from the rtl folder.
`timescale 1ns / 1ps

module auto_rate_fallback_controller_test;
  import arf_pkg::*;

  localparam int MAX_RATES      = 16;
  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 12;
  // The block answers in the cycle after it accepts a request; this settle time
  // is enough to be sure nothing is still on its way.
  localparam int SETTLE_CYCLES  = 3;
  // The longest quiet stretch in a correct run is the long receiver hold-off
  // plus idle gaps, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 48;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 272;

  // Command code 3 has no meaning; the block must answer it like an idle step.
  localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_MAX = {CFG_IDX_W{1'b1}};

  // Configuration phases: high, low and min use fixed extreme settings; the hold phase and the rest are random.
  localparam int PHASE_HIGH = 1;
  localparam int PHASE_LOW  = 2;
  localparam int PHASE_MIN  = 3;
  localparam int PHASE_HOLD = 4;

  // One row of the directed plan: either a register write or a request, with
  // an optional hand-written expected decision.
  typedef struct {
    bit                   is_cfg;
    logic [CMD_W-1:0]     cmd;
    logic [ATTEMPT_W-1:0] attempts;
    logic [SUCCESS_W-1:0] successes;
    logic [RATE_W-1:0]    chosen;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_data;
    bit                   typed;
    arf_result_t          decision;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     command       = CMD_QUERY;
  logic [ATTEMPT_W-1:0] attempt_count = '0;
  logic [SUCCESS_W-1:0] success_count = '0;
  logic [RATE_W-1:0]    rate_index    = '0;

  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [RATE_W-1:0]    proposed_rate;
  logic                 clear_success;
  logic                 invalid_rate;

  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_DAT_W-1:0] cfg_data      = '0;

  // Shadow of the configuration registers, updated when a write is accepted.
  logic [TIMER_W-1:0]   cfg_timer_ticks = RST_TIMER_TICKS;
  logic                 cfg_backoff     = 1'b0;
  logic [CFG_THR_W-1:0] cfg_init_thr    = RST_INIT_THR;
  logic [CFG_THR_W-1:0] cfg_max_thr     = RST_MAX_THR;
  logic [NRATES_W-1:0]  cfg_num_rates   = RST_NUM_RATES;

  // Rate controller state as the bench expects it to be.
  logic [RATE_W-1:0]    rate_now      = '0;
  logic                 probe_open    = 1'b0;
  logic                 timeout_seen  = 1'b0;
  logic [THR_W-1:0]     thr_now       = THR_W'(RST_INIT_THR);
  logic                 timer_on      = 1'b0;
  logic [TIMER_W-1:0]   timer_left    = '0;
  // Last rate offered by a query; random commits often pick it up, as a real
  // transmitter would.
  logic [RATE_W-1:0]    last_offer    = '0;

  arf_result_t pending_decisions[$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;

  // Shared idling controls: during bursts neither side inserts gaps, and a
  // hold request makes the receiver stall for a long stretch once.
  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;

  auto_rate_fallback_controller #(
    .MAX_RATES(MAX_RATES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .attempt_count(attempt_count),
    .success_count(success_count),
    .rate_index   (rate_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .proposed_rate(proposed_rate),
    .clear_success(clear_success),
    .invalid_rate (invalid_rate),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  // A step up is only offered while the current rate sits below the top rate;
  // a rate left above the top by a smaller rate count stays where it is.
  function automatic logic [RATE_W-1:0] step_up_rate(int top);
    return (int'(rate_now) < top) ? rate_now + RATE_W'(1) : rate_now;
  endfunction

  // Computes the decision for one request and advances the expected state.
  function automatic arf_result_t predict_decision(logic [CMD_W-1:0] cmd,
                                                   logic [ATTEMPT_W-1:0] attempts,
                                                   logic [SUCCESS_W-1:0] successes,
                                                   logic [RATE_W-1:0] chosen);
    int          top;
    int          doubled;
    arf_result_t res;
    // The rate count in use is clamped to 1..MAX_RATES.
    if (cfg_num_rates < 1) begin
      top = 0;
    end else if (cfg_num_rates > MAX_RATES) begin
      top = MAX_RATES - 1;
    end else begin
      top = int'(cfg_num_rates) - 1;
    end
    res.proposed_rate = rate_now;
    res.clear_success = 1'b0;
    res.invalid_rate  = 1'b0;
    case (cmd)
      CMD_QUERY: begin
        // A pending timeout wins over everything, then a failed probe or a
        // late attempt, then reaching the success threshold.
        if (timeout_seen) begin
          res.proposed_rate = step_up_rate(top);
        end else if ((probe_open && attempts == PROBE_FAIL_ATTEMPT) ||
                     attempts >= DOWN_ATTEMPT) begin
          res.proposed_rate = (rate_now > 0) ? rate_now - RATE_W'(1) : rate_now;
        end else if (THR_W'(successes) == thr_now) begin
          res.proposed_rate = step_up_rate(top);
        end
        last_offer = res.proposed_rate;
      end
      CMD_COMMIT: begin
        if (int'(chosen) > top) begin
          // An index outside the list leaves every bit of state alone.
          res.invalid_rate = 1'b1;
        end else begin
          timeout_seen = 1'b0;
          if (chosen == rate_now) begin
            probe_open = 1'b0;
          end else begin
            timer_on   = 1'b0;
            timer_left = '0;
            if (chosen < rate_now) begin
              timer_on   = 1'b1;
              timer_left = cfg_timer_ticks;
              if (probe_open) begin
                // With backoff on, a failed probe makes the next climb harder.
                probe_open = 1'b0;
                if (cfg_backoff && thr_now < THR_W'(cfg_max_thr)) begin
                  doubled = int'(thr_now) * 2;
                  thr_now = (doubled > int'(THR_SAT)) ? THR_SAT : THR_W'(doubled);
                end
              end else if (cfg_backoff) begin
                thr_now = thr_now / 2;
                if (thr_now < THR_W'(cfg_init_thr)) begin
                  thr_now = THR_W'(cfg_init_thr);
                end
              end
            end else begin
              probe_open = 1'b1;
            end
            rate_now          = chosen;
            res.clear_success = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (timer_on) begin
          if (timer_left > 1) begin
            timer_left = timer_left - 1;
          end else begin
            // A zero length expires on the first tick just like a length of one.
            timer_on   = 1'b0;
            timer_left = '0;
            if (int'(rate_now) != top) begin
              timeout_seen = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic arf_result_t decision_of(logic [RATE_W-1:0] rate, logic clr, logic inv);
    arf_result_t res;
    res.proposed_rate = rate;
    res.clear_success = clr;
    res.invalid_rate  = inv;
    return res;
  endfunction

  function automatic plan_row_t request_row(logic [CMD_W-1:0] cmd, int attempts,
                                            int successes, int chosen, bit typed,
                                            arf_result_t decision);
    plan_row_t row;
    row.is_cfg    = 1'b0;
    row.cmd       = cmd;
    row.attempts  = ATTEMPT_W'(attempts);
    row.successes = SUCCESS_W'(successes);
    row.chosen    = RATE_W'(chosen);
    row.reg_idx   = '0;
    row.reg_data  = '0;
    row.typed     = typed;
    row.decision  = decision;
    return row;
  endfunction

  function automatic plan_row_t config_row(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DAT_W-1:0] data);
    plan_row_t row;
    row          = request_row(CMD_QUERY, 0, 0, 0, 1'b0, '0);
    row.is_cfg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  // Offers one request after a random gap and holds it until it is taken.
  // With a zero gap valid simply stays high from the previous request.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [ATTEMPT_W-1:0] attempts,
                              logic [SUCCESS_W-1:0] successes, logic [RATE_W-1:0] chosen,
                              bit typed, arf_result_t decision);
    int          gap;
    arf_result_t predicted;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    attempt_count <= attempts;
    success_count <= successes;
    rate_index    <= chosen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // The predictor always runs so that its state keeps up, even where a
    // hand-written decision is checked instead.
    predicted = predict_decision(cmd, attempts, successes, chosen);
    pending_decisions = {pending_decisions, (typed ? decision : predicted)};
  endtask

  // Stops offering requests and waits until every decision has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TIMER_TICKS: cfg_timer_ticks = data[TIMER_W-1:0];
      REG_EXP_BACKOFF: cfg_backoff     = data[0];
      REG_INIT_THR:    cfg_init_thr    = data[CFG_THR_W-1:0];
      REG_MAX_THR:     cfg_max_thr     = data[CFG_THR_W-1:0];
      REG_NUM_RATES:   cfg_num_rates   = data[NRATES_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Chooses a register value for a phase. Random phases put junk in the
  // unused upper bits, which the block has to drop.
  function automatic logic [CFG_DAT_W-1:0] pick_reg_value(int r, int phase);
    logic [CFG_DAT_W-1:0] junk;
    int                   sel;
    junk = $urandom;
    sel  = $urandom_range(0, 99);
    case (r)
      REG_TIMER_TICKS: begin
        if (phase == PHASE_HIGH) return {CFG_DAT_W{1'b1}};
        if (phase == PHASE_LOW)  return '0;
        if (phase == PHASE_MIN)  return 1;
        // Short timers keep expiries frequent; now and then a long one.
        if (sel < 70) return $urandom_range(0, 8);
        if (sel < 90) return $urandom_range(9, 60);
        return $urandom;
      end
      REG_EXP_BACKOFF: begin
        if (phase == PHASE_HIGH || phase == PHASE_MIN) return 1;
        if (phase == PHASE_LOW) return 0;
        return (junk << 1) | CFG_DAT_W'($urandom_range(0, 1));
      end
      REG_INIT_THR: begin
        if (phase == PHASE_HIGH) return {CFG_THR_W{1'b1}};
        if (phase == PHASE_LOW)  return 0;
        if (phase == PHASE_MIN)  return 1;
        return (junk << CFG_THR_W) |
               CFG_DAT_W'((sel < 70) ? $urandom_range(1, 30) : $urandom_range(0, 1023));
      end
      REG_MAX_THR: begin
        if (phase == PHASE_HIGH || phase == PHASE_MIN) return {CFG_THR_W{1'b1}};
        if (phase == PHASE_LOW) return 0;
        return (junk << CFG_THR_W) |
               CFG_DAT_W'((sel < 70) ? $urandom_range(1, 200) : $urandom_range(0, 1023));
      end
      default: begin
        // Rate count: 31 and 0 exercise the clamp, 1 the single rate.
        if (phase == PHASE_HIGH) return {NRATES_W{1'b1}};
        if (phase == PHASE_LOW)  return 0;
        if (phase == PHASE_MIN)  return 1;
        return (junk << NRATES_W) |
               CFG_DAT_W'((sel < 80) ? $urandom_range(1, MAX_RATES) : $urandom_range(0, 31));
      end
    endcase
  endfunction

  // Mostly realistic traffic: queries with low attempt numbers and success
  // counts near the threshold, commits of the rate just offered, and ticks.
  task automatic random_request();
    int                   sel;
    logic [CMD_W-1:0]     cmd;
    logic [ATTEMPT_W-1:0] attempts;
    logic [SUCCESS_W-1:0] successes;
    logic [RATE_W-1:0]    chosen;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      cmd = CMD_QUERY;
    end else if (sel < 70) begin
      cmd = CMD_COMMIT;
    end else if (sel < 97) begin
      cmd = CMD_TICK;
    end else begin
      cmd = CMD_UNUSED;
    end
    attempts = ($urandom_range(0, 99) < 80) ? ATTEMPT_W'($urandom_range(0, 4))
                                            : ATTEMPT_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 60) begin
      successes = SUCCESS_W'(thr_now) + SUCCESS_W'($urandom_range(0, 2)) - SUCCESS_W'(1);
    end else begin
      successes = SUCCESS_W'($urandom_range(0, 4095));
    end
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      chosen = last_offer;
    end else if (sel < 75) begin
      chosen = $urandom_range(0, 1) ? rate_now + RATE_W'(1) : rate_now - RATE_W'(1);
    end else begin
      chosen = RATE_W'($urandom_range(0, 15));
    end
    send_request(cmd, attempts, successes, chosen, 1'b0, '0);
  endtask

  // Main stimulus: a directed plan that starts from the reset settings, then random
  // phases, each opened by a full set of register writes.
  initial begin : stimulus
    plan_row_t plan[$];
    plan_row_t row;
    int        phase;
    int        i;
    int        r;

    // Reset defaults: eight rates, threshold ten, timer 1000, no backoff.
    plan = {plan, request_row(CMD_QUERY, 0, 0, 0, 1'b1, decision_of(0, 0, 0))};
    plan = {plan, request_row(CMD_QUERY, 255, 4095, 15, 1'b1, decision_of(0, 0, 0))};
    plan = {plan, request_row(CMD_QUERY, 0, 10, 0, 1'b1, decision_of(1, 0, 0))};
    plan = {plan, request_row(CMD_UNUSED, 255, 4095, 15, 1'b1, decision_of(0, 0, 0))};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 15, 1'b1, decision_of(0, 0, 1))};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 8, 1'b1, decision_of(0, 0, 1))};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 1, 1'b1, decision_of(0, 1, 0))};
    // Second attempt after a step up counts as a failed probe.
    plan = {plan, request_row(CMD_QUERY, 2, 0, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_TICK, 0, 0, 0, 1'b0, '0)};
    plan = {plan, config_row(REG_TIMER_TICKS, 1)};
    plan = {plan, config_row(REG_EXP_BACKOFF, 1)};
    // Committing the current rate keeps the timer running and clears nothing.
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 0, 1'b1, decision_of(0, 0, 0))};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 1, 1'b1, decision_of(0, 1, 0))};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 0, 1'b1, decision_of(1, 1, 0))};
    plan = {plan, request_row(CMD_QUERY, 0, 20, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_TICK, 0, 0, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_QUERY, 255, 0, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_TICK, 0, 0, 0, 1'b0, '0)};
    // A zero timer length runs out on the very first tick.
    plan = {plan, config_row(REG_TIMER_TICKS, 0)};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 1, 1'b0, '0)};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_TICK, 0, 0, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 7, 1'b0, '0)};
    // Shrinking the rate list leaves the current rate above the top.
    plan = {plan, config_row(REG_NUM_RATES, 2)};
    plan = {plan, request_row(CMD_QUERY, 3, 0, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_QUERY, 0, 40, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 7, 1'b1, decision_of(7, 0, 1))};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 1, 1'b0, '0)};
    plan = {plan, request_row(CMD_TICK, 0, 0, 0, 1'b0, '0)};
    // Rate counts outside 1..16 are clamped at both ends.
    plan = {plan, config_row(REG_NUM_RATES, 31)};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 15, 1'b0, '0)};
    plan = {plan, config_row(REG_NUM_RATES, 0)};
    plan = {plan, request_row(CMD_QUERY, 0, 80, 0, 1'b0, '0)};
    plan = {plan, request_row(CMD_COMMIT, 0, 0, 0, 1'b0, '0)};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      row = plan[k];
      if (row.is_cfg) begin
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_request(row.cmd, row.attempts, row.successes, row.chosen, row.typed,
                     row.decision);
      end
    end

    for (phase = 1; phase <= RANDOM_PHASES; phase++) begin
      for (r = REG_TIMER_TICKS; r <= REG_NUM_RATES; r++) begin
        write_reg(CFG_IDX_W'(r), pick_reg_value(r, phase));
      end
      // Writes to indexes past the list must be ignored.
      if (phase > PHASE_MIN) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_NUM_RATES + 1, REG_IDX_MAX)), $urandom);
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // The last quarter of every 200 requests runs back to back.
        no_idle = ((i % 200) >= 150);
        if (phase == PHASE_HOLD && i == 40) begin
          hold_request = 1'b1;
        end
        random_request();
      end
      no_idle = 1'b0;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: stalls a random number of cycles before each decision, and once
  // holds off long enough that the block has to stall its request side.
  initial begin : receiver
    int stall_len;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_len    = LONG_HOLD;
      end else begin
        stall_len = idle_cycles();
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Every decision taken from the block is compared with the oldest one the
  // bench is waiting for.
  always @(posedge clk) begin
    arf_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        $display("%0t: decision with none expected, actual rate %0d clear %0b invalid %0b",
                 $time, proposed_rate, clear_success, invalid_rate);
        mismatch_count++;
      end else begin
        want = pending_decisions.pop_front();
        if (proposed_rate !== want.proposed_rate) begin
          $display("%0t: proposed_rate expected %0d actual %0d",
                   $time, want.proposed_rate, proposed_rate);
          mismatch_count++;
        end
        if (clear_success !== want.clear_success) begin
          $display("%0t: clear_success expected %0b actual %0b",
                   $time, want.clear_success, clear_success);
          mismatch_count++;
        end
        if (invalid_rate !== want.invalid_rate) begin
          $display("%0t: invalid_rate expected %0b actual %0b",
                   $time, want.invalid_rate, invalid_rate);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no handshake on any channel means
  // the block has hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
